// ===== rtl/core/mcf_pkg.sv =====
// Shared types and constants for the multichannel FIR filter.
// Command/status structs between controller and datapath, op codes, widths.
// No dependencies.
`default_nettype none

package mcf_pkg;

    localparam int CHANNELS   = 8;
    localparam int TAPS       = 16;

    localparam int OP_W       = 2;
    localparam int CH_W       = 3;
    localparam int SAMPLE_W   = 16;
    localparam int TI_W       = 4;
    localparam int WEIGHT_W   = 16;
    localparam int FILT_W     = 32;

    localparam int TAP_CFG_W  = 5;
    localparam int CH_CFG_W   = 4;
    localparam int CFG_W      = 5;
    localparam int CFG_IDX_W  = 1;

    localparam int SLOT_W     = $clog2(TAPS);
    localparam int TCNT_W     = $clog2(TAPS + 1);
    localparam int NCH_W      = $clog2(CHANNELS + 1);
    localparam int HIST_DEPTH = CHANNELS * TAPS;
    localparam int HIST_AW    = $clog2(HIST_DEPTH);
    localparam int PROD_W     = SAMPLE_W + WEIGHT_W;
    localparam int ACC_W      = PROD_W + $clog2(TAPS);
    localparam int FRAC_W     = 14;

    localparam int IN_DATA_W  = 40;
    localparam int IN_USER_W  = 2;
    localparam int OUT_DATA_W = 40;

    localparam logic [CFG_IDX_W-1:0] CFG_TAPS     = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_CHANNELS = 1'd1;

    localparam logic [TAP_CFG_W-1:0] TAP_CFG_RST = 5'd16;
    localparam logic [CH_CFG_W-1:0]  CH_CFG_RST  = 4'd1;

    typedef enum logic [OP_W-1:0] {
        OP_LOAD   = 2'd0,
        OP_SAMPLE = 2'd1,
        OP_CLEAR  = 2'd2
    } t_op;

    typedef struct packed {
        logic wr_weight;
        logic clear_hist;
        logic capture;
        logic slot_reduce;
        logic hist_write;
        logic rd_issue;
        logic commit;
        logic load_out;
    } t_cmd;

    typedef struct packed {
        logic ch_ok;
        logic slot_ge_t;
        logic last_tap;
        logic mac_busy;
        logic out_busy;
    } t_sts;

endpackage

`default_nettype wire

// ===== rtl/core/mcf_ram.sv =====
// Generic single-port-write, single-port-read RAM with registered read data.
// No dependencies.
`default_nettype none

module mcf_ram #(
    parameter int WIDTH = 16,
    parameter int DEPTH = 128
) (
    input  wire logic                     i_clk,
    input  wire logic                     i_we,
    input  wire logic [$clog2(DEPTH)-1:0] i_waddr,
    input  wire logic [WIDTH-1:0]         i_wdata,
    input  wire logic                     i_re,
    input  wire logic [$clog2(DEPTH)-1:0] i_raddr,
    output logic      [WIDTH-1:0]         o_rdata
);

    logic [WIDTH-1:0] r_mem [DEPTH];

    always_ff @(posedge i_clk) begin
        if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        if (i_re) begin
            o_rdata <= r_mem[i_raddr];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mcf_ctrl.sv =====
// Controller for the multichannel FIR filter: sequences one transaction at a time.
// Depends on mcf_pkg (t_cmd, t_sts, t_op).
`default_nettype none

module mcf_ctrl
    import mcf_pkg::*;
(
    input  wire logic            i_clk,
    input  wire logic            i_rst_n,
    input  wire logic            i_valid,
    input  wire logic [OP_W-1:0] i_op,
    output logic                 o_ready,
    input  wire t_sts            i_sts,
    output t_cmd                 o_cmd
);

    typedef enum logic [2:0] {
        S_IDLE,
        S_MOD,
        S_WRITE,
        S_READ,
        S_DRAIN,
        S_DONE
    } t_state;

    t_state r_state;
    t_state n_state;
    logic   w_accept;

    assign o_ready  = (r_state == S_IDLE);
    assign w_accept = i_valid && o_ready;

    always_comb begin
        o_cmd   = '0;
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_accept) begin
                    case (t_op'(i_op))
                        OP_LOAD:  o_cmd.wr_weight  = 1'b1;
                        OP_CLEAR: o_cmd.clear_hist = 1'b1;
                        OP_SAMPLE: begin
                            // drop samples of channels outside the frame
                            if (i_sts.ch_ok) begin
                                o_cmd.capture = 1'b1;
                                n_state       = S_MOD;
                            end
                        end
                        default: ;
                    endcase
                end
            end
            S_MOD: begin
                // wrap a stale slot left over from a larger tap count
                if (i_sts.slot_ge_t) begin
                    o_cmd.slot_reduce = 1'b1;
                end else begin
                    n_state = S_WRITE;
                end
            end
            S_WRITE: begin
                o_cmd.hist_write = 1'b1;
                n_state          = S_READ;
            end
            S_READ: begin
                o_cmd.rd_issue = 1'b1;
                if (i_sts.last_tap) begin
                    n_state = S_DRAIN;
                end
            end
            S_DRAIN: begin
                if (!i_sts.mac_busy) begin
                    n_state = S_DONE;
                end
            end
            S_DONE: begin
                // hold the sum until the output register frees up
                if (!i_sts.out_busy) begin
                    o_cmd.load_out = 1'b1;
                    o_cmd.commit   = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/core/mcf_datapath.sv =====
// Datapath for the multichannel FIR filter: config, weights, history RAM with
// valid bits, slot and tap counters, multiply-accumulate pipeline, output register.
// Depends on mcf_pkg and mcf_ram.
`default_nettype none

module mcf_datapath
    import mcf_pkg::*;
(
    input  wire logic                       i_clk,
    input  wire logic                       i_rst_n,
    input  wire logic                       i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]       i_cfg_index,
    input  wire logic [CFG_W-1:0]           i_cfg_wdata,
    input  wire logic [CH_W-1:0]            i_channel,
    input  wire logic signed [SAMPLE_W-1:0] i_sample,
    input  wire logic [TI_W-1:0]            i_tap_index,
    input  wire logic signed [WEIGHT_W-1:0] i_weight,
    input  wire t_cmd                       i_cmd,
    output t_sts                            o_sts,
    input  wire logic                       i_m_tready,
    output logic                            o_m_tvalid,
    output logic [CH_W-1:0]                 o_out_channel,
    output logic signed [FILT_W-1:0]        o_filtered
);

    logic [TAP_CFG_W-1:0]        r_tap_cfg;
    logic [CH_CFG_W-1:0]         r_ch_cfg;
    logic signed [WEIGHT_W-1:0]  r_weights [TAPS];
    logic [SLOT_W-1:0]           r_frame_slot;
    logic [SLOT_W-1:0]           r_slot;
    logic [SLOT_W-1:0]           r_pos;
    logic [SLOT_W-1:0]           r_j;
    logic [CH_W-1:0]             r_ch;
    logic signed [SAMPLE_W-1:0]  r_sample;
    logic [HIST_DEPTH-1:0]       r_hvalid;

    logic                        r_p1_vld;
    logic                        r_p1_hv;
    logic [SLOT_W-1:0]           r_p1_j;
    logic                        r_p2_vld;
    logic signed [PROD_W-1:0]    r_prod;
    logic signed [ACC_W-1:0]     r_acc;

    logic [TCNT_W-1:0]           w_taps;
    logic [NCH_W-1:0]            w_nch;
    logic [TCNT_W-1:0]           w_slot_ext;
    logic [TCNT_W-1:0]           w_half;
    logic [TCNT_W-1:0]           w_age0;
    logic [SLOT_W-1:0]           w_pos0;
    logic [SLOT_W-1:0]           w_pos_next;
    logic [SLOT_W-1:0]           w_slot_next;
    logic [HIST_AW-1:0]          w_base;
    logic [HIST_AW-1:0]          w_waddr;
    logic [HIST_AW-1:0]          w_raddr;
    logic [SAMPLE_W-1:0]         w_rd_data;
    logic signed [SAMPLE_W-1:0]  w_hsamp;
    logic                        w_last_ch;

    // effective counts: zero acts as one, oversize clamps to the array size
    always_comb begin
        if (r_tap_cfg == '0) begin
            w_taps = TCNT_W'(1);
        end else if (32'(r_tap_cfg) > TAPS) begin
            w_taps = TCNT_W'(TAPS);
        end else begin
            w_taps = TCNT_W'(r_tap_cfg);
        end
        if (r_ch_cfg == '0) begin
            w_nch = NCH_W'(1);
        end else if (32'(r_ch_cfg) > CHANNELS) begin
            w_nch = NCH_W'(CHANNELS);
        end else begin
            w_nch = NCH_W'(r_ch_cfg);
        end
    end

    // first read position: weight 0 pairs with age t/2-1 (age 0 when one tap)
    assign w_slot_ext = TCNT_W'(r_slot);
    assign w_half     = w_taps >> 1;
    assign w_age0     = (w_half == '0) ? '0 : w_half - TCNT_W'(1);
    assign w_pos0     = (w_slot_ext >= w_age0) ? SLOT_W'(w_slot_ext - w_age0)
                                               : SLOT_W'(w_slot_ext + w_taps - w_age0);
    assign w_pos_next = (TCNT_W'(r_pos) + TCNT_W'(1) == w_taps) ? '0
                                                                : r_pos + SLOT_W'(1);
    assign w_slot_next = (w_slot_ext + TCNT_W'(1) >= w_taps) ? '0 : r_slot + SLOT_W'(1);
    assign w_last_ch   = (32'(r_ch) == 32'(w_nch) - 32'd1);

    assign w_base  = HIST_AW'(32'(r_ch) * TAPS);
    assign w_waddr = w_base + HIST_AW'(r_slot);
    assign w_raddr = w_base + HIST_AW'(r_pos);

    mcf_ram #(
        .WIDTH(SAMPLE_W),
        .DEPTH(HIST_DEPTH)
    ) u_hist (
        .i_clk  (i_clk),
        .i_we   (i_cmd.hist_write),
        .i_waddr(w_waddr),
        .i_wdata(r_sample),
        .i_re   (i_cmd.rd_issue),
        .i_raddr(w_raddr),
        .o_rdata(w_rd_data)
    );

    // entries never written since reset or clear read as zero
    assign w_hsamp = r_p1_hv ? signed'(w_rd_data) : '0;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_tap_cfg    <= TAP_CFG_RST;
            r_ch_cfg     <= CH_CFG_RST;
            r_frame_slot <= '0;
            r_hvalid     <= '0;
            r_p1_vld     <= 1'b0;
            r_p2_vld     <= 1'b0;
            o_m_tvalid   <= 1'b0;
            for (int i = 0; i < TAPS; i++) begin
                r_weights[i] <= '0;
            end
        end else begin
            if (i_cfg_we) begin
                case (i_cfg_index)
                    CFG_TAPS:     r_tap_cfg <= i_cfg_wdata[TAP_CFG_W-1:0];
                    CFG_CHANNELS: r_ch_cfg  <= i_cfg_wdata[CH_CFG_W-1:0];
                    default: ;
                endcase
            end
            if (i_cmd.wr_weight && (32'(i_tap_index) < TAPS)) begin
                r_weights[SLOT_W'(i_tap_index)] <= i_weight;
            end
            if (i_cmd.clear_hist) begin
                r_hvalid <= '0;
            end else if (i_cmd.hist_write) begin
                r_hvalid[w_waddr] <= 1'b1;
            end
            if (i_cmd.commit) begin
                r_frame_slot <= w_last_ch ? w_slot_next : r_slot;
            end
            r_p1_vld <= i_cmd.rd_issue;
            r_p2_vld <= r_p1_vld;
            if (i_cmd.load_out) begin
                o_m_tvalid <= 1'b1;
            end else if (i_m_tready) begin
                o_m_tvalid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_ch     <= i_channel;
            r_sample <= i_sample;
            r_slot   <= r_frame_slot;
        end else if (i_cmd.slot_reduce) begin
            r_slot <= SLOT_W'(w_slot_ext - w_taps);
        end
        if (i_cmd.hist_write) begin
            r_pos <= w_pos0;
            r_j   <= '0;
            r_acc <= '0;
        end else if (i_cmd.rd_issue) begin
            r_pos <= w_pos_next;
            r_j   <= r_j + SLOT_W'(1);
        end
        r_p1_hv <= r_hvalid[w_raddr];
        r_p1_j  <= r_j;
        r_prod  <= w_hsamp * r_weights[r_p1_j];
        if (r_p2_vld) begin
            r_acc <= r_acc + ACC_W'(r_prod);
        end
        if (i_cmd.load_out) begin
            o_out_channel <= r_ch;
            // after the shift the sum fits 32 bits, so the truncation to 32 bits loses nothing
            o_filtered    <= FILT_W'(r_acc >>> FRAC_W);
        end
    end

    assign o_sts.ch_ok     = (32'(i_channel) < 32'(w_nch));
    assign o_sts.slot_ge_t = (w_slot_ext >= w_taps);
    assign o_sts.last_tap  = (TCNT_W'(r_j) == w_taps - TCNT_W'(1));
    assign o_sts.mac_busy  = r_p1_vld || r_p2_vld;
    assign o_sts.out_busy  = o_m_tvalid && !i_m_tready;

    a_write_idle_pipe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.hist_write |-> !r_p1_vld && !r_p2_vld)
        else $error("history written while taps still in flight");

    a_pos_in_ring: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.rd_issue |-> (TCNT_W'(r_pos) < w_taps))
        else $error("read position outside the ring");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!o_m_tvalid || i_m_tready))
        else $error("output overwritten while stalled");

    a_reset_clears: assert property (@(posedge i_clk)
        !i_rst_n |=> (r_hvalid == '0) && !o_m_tvalid)
        else $error("history valid bits not cleared by reset");

endmodule

`default_nettype wire

// ===== rtl/core/multichannel_fir_filter.sv =====
// Multichannel FIR filter, top level: stream ports, controller and datapath.
// Depends on mcf_pkg, mcf_ctrl, mcf_datapath (and mcf_ram through it).
//
// Usage: the slave stream carries one transaction per item; tuser holds the op
// (load weight, sample, clear history), tdata the channel, sample, tap index
// and weight. A load or a clear gives no result. A sample
// of a channel below the channel count writes that channel's history ring and
// returns one master-stream item with the channel and the filtered value.
// A sample first wraps the stored frame slot down when it is not below a
// lowered tap count. One item is in work at a time: the next item is taken
// only once a sample's result is loaded into the output register, since the
// single shared multiply-accumulate walks the taps through one history RAM
// read port. A finished result waits in the output register; while the
// receiver stalls, one more sample is accepted and its result holds inside
// until the output register frees.
// Reset clears the weights, the history (through per-entry valid bits, no
// sweep), the frame slot and sets tap_count to 16, channel_count to 1.
// Write configuration only while no sample is in work.
`default_nettype none

module multichannel_fir_filter
    import mcf_pkg::*;
(
    input  wire logic                  i_clk,
    input  wire logic                  i_rst_n,
    input  wire logic                  i_cfg_we,
    input  wire logic [CFG_IDX_W-1:0]  i_cfg_index,
    input  wire logic [CFG_W-1:0]      i_cfg_wdata,
    input  wire logic                  i_s_axis_tvalid,
    output logic                       o_s_axis_tready,
    // tdata: channel[2:0], sample[18:3], tap_index[22:19], weight[38:23], zero
    input  wire logic [IN_DATA_W-1:0]  i_s_axis_tdata,
    // tuser: op[1:0]
    input  wire logic [IN_USER_W-1:0]  i_s_axis_tuser,
    output logic                       o_m_axis_tvalid,
    input  wire logic                  i_m_axis_tready,
    // tdata: out_channel[2:0], filtered[34:3], zero
    output logic [OUT_DATA_W-1:0]      o_m_axis_tdata
);

    localparam int SAMPLE_LO = CH_W;
    localparam int TI_LO     = SAMPLE_LO + SAMPLE_W;
    localparam int WEIGHT_LO = TI_LO + TI_W;

    t_cmd                       w_cmd;
    t_sts                       w_sts;
    logic [CH_W-1:0]            w_out_channel;
    logic signed [FILT_W-1:0]   w_filtered;

    mcf_ctrl u_ctrl (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_valid(i_s_axis_tvalid),
        .i_op   (i_s_axis_tuser[OP_W-1:0]),
        .o_ready(o_s_axis_tready),
        .i_sts  (w_sts),
        .o_cmd  (w_cmd)
    );

    mcf_datapath u_dp (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_cfg_we     (i_cfg_we),
        .i_cfg_index  (i_cfg_index),
        .i_cfg_wdata  (i_cfg_wdata),
        .i_channel    (i_s_axis_tdata[CH_W-1:0]),
        .i_sample     (signed'(i_s_axis_tdata[TI_LO-1:SAMPLE_LO])),
        .i_tap_index  (i_s_axis_tdata[WEIGHT_LO-1:TI_LO]),
        .i_weight     (signed'(i_s_axis_tdata[WEIGHT_LO+WEIGHT_W-1:WEIGHT_LO])),
        .i_cmd        (w_cmd),
        .o_sts        (w_sts),
        .i_m_tready   (i_m_axis_tready),
        .o_m_tvalid   (o_m_axis_tvalid),
        .o_out_channel(w_out_channel),
        .o_filtered   (w_filtered)
    );

    assign o_m_axis_tdata = {{(OUT_DATA_W - FILT_W - CH_W){1'b0}}, w_filtered, w_out_channel};

endmodule

`default_nettype wire
